@@ rtl/pressure_temperature_compensation_macros.svh @@
// Assertion macros for the pressure and temperature compensation block.
// The macros expect clk_i and rst_ni in the scope where they are used.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ptc_pkg.sv @@
// Package for the pressure and temperature compensation block.
// Holds the sequencer states, divider handshake types, constants and helpers.
`timescale 1ns / 1ps

package ptc_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_CAL_TEMP    = 2'd0;
  localparam logic [1:0] CFG_CAL_PRESS_A = 2'd1;
  localparam logic [1:0] CFG_CAL_PRESS_B = 2'd2;
  localparam logic [1:0] CFG_CAL_PRESS_C = 2'd3;

  // Constants of the compensation formulae.
  localparam logic [31:0] PRESS_OFFSET = 32'd64000;
  localparam logic [31:0] PRESS_SCALE  = 32'd3125;
  localparam logic [20:0] RAW_FULL     = 21'd1048576;
  localparam logic [31:0] HALF_RANGE   = 32'h8000_0000;
  localparam logic [31:0] ONE_Q15      = 32'd32768;
  localparam logic [31:0] ROUND_T      = 32'd128;
  localparam logic [31:0] TEMP_SCALE   = 32'd5;

  // Number of quotient bits produced by the divider, one per cycle.
  localparam int unsigned DIV_BITS = 32;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T_MUL0,
    ST_T_MUL1,
    ST_T_MUL2,
    ST_T_FINE,
    ST_T_MUL5,
    ST_T_CENTI,
    ST_P_Q2,
    ST_P_P6,
    ST_P_P5,
    ST_P_SUMB,
    ST_P_P2,
    ST_P_SUMA,
    ST_P_OFFS,
    ST_P_P1,
    ST_P_SCALE,
    ST_P_CHECK,
    ST_DIV,
    ST_C_SQ,
    ST_C_P9,
    ST_C_P8,
    ST_C_SUM,
    ST_C_FINAL,
    ST_OUT
  } state_e;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  // Status and result of the divider.
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  // Arithmetic right shift of a 32-bit two's complement pattern.
  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    asr = $unsigned($signed(x) >>> n);
  endfunction

  // Sign extension of a 16-bit calibration word.
  function automatic logic [31:0] sext16(input logic [15:0] x);
    sext16 = {{16{x[15]}}, x};
  endfunction

endpackage

@@ rtl/ptc_stream_if.sv @@
// Valid/ready channel interfaces for the compensation block.
// Depends on nothing; one interface for samples in, one for results out.
`timescale 1ns / 1ps

// Raw sample channel.
interface ptc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temp;
  logic [19:0] raw_press;

  modport source (output valid, output raw_temp, output raw_press, input ready);
  modport sink (input valid, input raw_temp, input raw_press, output ready);
endinterface

// Compensated result channel.
interface ptc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temp_centi;
  logic signed [31:0] fine_temp_out;
  logic        [31:0] pressure_pa;
  logic               div_zero;

  modport source (
    output valid, output temp_centi, output fine_temp_out, output pressure_pa,
    output div_zero, input ready
  );
  modport sink (
    input valid, input temp_centi, input fine_temp_out, input pressure_pa,
    input div_zero, output ready
  );
endinterface

@@ rtl/ptc_div.sv @@
// Radix-2 restoring divider, 32-bit unsigned, one quotient bit per cycle.
// Depends on ptc_pkg for the request and response structs and for DIV_BITS.
`timescale 1ns / 1ps

module ptc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptc_pkg::div_req_t req_i,
  output ptc_pkg::div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  // One shift-and-subtract step on the partial remainder.
  assign trial = {rem_q, quo_q[31]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[31:0] : trial[31:0];
      quo_d = {quo_q[30:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(ptc_pkg::DIV_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ rtl/pressure_temperature_compensation.sv @@
// Top level of the 32-bit integer barometric pressure and temperature compensation.
// Depends on ptc_pkg, the channel interfaces, ptc_div and the assertion macro header.
`timescale 1ns / 1ps

// One transaction carries a raw temperature and a raw pressure sample and yields one
// result: temperature in 0.01 degC, the fine temperature, pressure in pascals and a flag
// for a zero pressure divisor. The block works on one transaction at a time: it offers
// the result and goes back to idle before it accepts the next transaction. The work is
// done by 22 sequencer steps around a single 32x32 multiplier and a bit-serial divider.
// When the fine temperature is zero the pressure is not recomputed and the previous
// pressure is repeated; when the divisor is zero the pressure is 0 and the divider is
// skipped. A finished result waits in an output register, so the next transaction is
// taken while it is still unread. Calibration registers are written through the
// configuration port; the user must write them only while the block is idle, which
// the block itself does not enforce.
`include "pressure_temperature_compensation_macros.svh"

module pressure_temperature_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_wdata_i,
  ptc_in_if.sink      in_i,
  ptc_out_if.source   out_o
);

  ptc_pkg::state_e state_q, state_d;

  // Calibration registers.
  logic [47:0] cal_temp_q, cal_press_a_q, cal_press_b_q, cal_press_c_q;

  // Working registers of the sequencer.
  logic [31:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic [31:0] d_q, d_d;
  logic [31:0] qq_q, qq_d;
  logic [31:0] p_q, p_d;
  logic [31:0] prod_q, prod_d;
  logic [31:0] temp_q, temp_d;
  logic [31:0] fine_q, fine_d;
  logic [31:0] last_q, last_d;
  logic [20:0] pn_q, pn_d;
  logic        dz_q, dz_d;
  logic        branch_q, branch_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_temp_q, out_temp_d;
  logic [31:0] out_fine_q, out_fine_d;
  logic [31:0] out_press_q, out_press_d;
  logic        out_dz_q, out_dz_d;

  // Shared multiplier.
  logic        mul_en;
  logic [31:0] mul_a, mul_b, mul_res;

  // Divider handshake.
  ptc_pkg::div_req_t div_req;
  ptc_pkg::div_rsp_t div_rsp;

  // Calibration words.
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

  logic in_acc;

  assign t1 = {16'd0, cal_temp_q[15:0]};
  assign t2 = ptc_pkg::sext16(cal_temp_q[31:16]);
  assign t3 = ptc_pkg::sext16(cal_temp_q[47:32]);
  assign p1 = {16'd0, cal_press_a_q[15:0]};
  assign p2 = ptc_pkg::sext16(cal_press_a_q[31:16]);
  assign p3 = ptc_pkg::sext16(cal_press_a_q[47:32]);
  assign p4 = ptc_pkg::sext16(cal_press_b_q[15:0]);
  assign p5 = ptc_pkg::sext16(cal_press_b_q[31:16]);
  assign p6 = ptc_pkg::sext16(cal_press_b_q[47:32]);
  assign p7 = ptc_pkg::sext16(cal_press_c_q[15:0]);
  assign p8 = ptc_pkg::sext16(cal_press_c_q[31:16]);
  assign p9 = ptc_pkg::sext16(cal_press_c_q[47:32]);

  assign in_i.ready = (state_q == ptc_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // Low 32 bits of the product wrap exactly like int32 multiplication.
  assign mul_res = mul_a * mul_b;

  ptc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer: next state, operand selection and register updates.
  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    b_d       = b_q;
    d_d       = d_q;
    qq_d      = qq_q;
    p_d       = p_q;
    temp_d    = temp_q;
    fine_d    = fine_q;
    last_d    = last_q;
    pn_d      = pn_q;
    dz_d      = dz_q;
    branch_d  = branch_q;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    out_temp_d  = out_temp_q;
    out_fine_d  = out_fine_q;
    out_press_d = out_press_q;
    out_dz_d    = out_dz_q;
    out_valid_d = out_valid_q && !out_o.ready;
    div_req.start    = 1'b0;
    div_req.dividend = prod_q[31] ? prod_q : {prod_q[30:0], 1'b0};
    div_req.divisor  = a_q;

    unique case (state_q)
      ptc_pkg::ST_IDLE: begin
        if (in_acc) begin
          a_d  = ({15'd0, in_i.raw_temp[19:3]}) - {t1[30:0], 1'b0};
          d_d  = {16'd0, in_i.raw_temp[19:4]} - t1;
          pn_d = ptc_pkg::RAW_FULL - {1'b0, in_i.raw_press};
          state_d = ptc_pkg::ST_T_MUL0;
        end
      end
      ptc_pkg::ST_T_MUL0: begin
        mul_en  = 1'b1;
        mul_a   = a_q;
        mul_b   = t2;
        state_d = ptc_pkg::ST_T_MUL1;
      end
      ptc_pkg::ST_T_MUL1: begin
        a_d     = ptc_pkg::asr(prod_q, 5'd11);
        mul_en  = 1'b1;
        mul_a   = d_q;
        mul_b   = d_q;
        state_d = ptc_pkg::ST_T_MUL2;
      end
      ptc_pkg::ST_T_MUL2: begin
        mul_en  = 1'b1;
        mul_a   = ptc_pkg::asr(prod_q, 5'd12);
        mul_b   = t3;
        state_d = ptc_pkg::ST_T_FINE;
      end
      ptc_pkg::ST_T_FINE: begin
        fine_d  = a_q + ptc_pkg::asr(prod_q, 5'd14);
        state_d = ptc_pkg::ST_T_MUL5;
      end
      ptc_pkg::ST_T_MUL5: begin
        mul_en  = 1'b1;
        mul_a   = fine_q;
        mul_b   = ptc_pkg::TEMP_SCALE;
        state_d = ptc_pkg::ST_T_CENTI;
      end
      ptc_pkg::ST_T_CENTI: begin
        temp_d = ptc_pkg::asr(prod_q + ptc_pkg::ROUND_T, 5'd8);
        // A zero fine temperature keeps the previous pressure.
        if (fine_q == '0) begin
          dz_d    = 1'b0;
          state_d = ptc_pkg::ST_OUT;
        end else begin
          a_d     = ptc_pkg::asr(fine_q, 5'd1) - ptc_pkg::PRESS_OFFSET;
          state_d = ptc_pkg::ST_P_Q2;
        end
      end
      ptc_pkg::ST_P_Q2: begin
        mul_en  = 1'b1;
        mul_a   = ptc_pkg::asr(a_q, 5'd2);
        mul_b   = ptc_pkg::asr(a_q, 5'd2);
        state_d = ptc_pkg::ST_P_P6;
      end
      ptc_pkg::ST_P_P6: begin
        qq_d    = prod_q;
        mul_en  = 1'b1;
        mul_a   = ptc_pkg::asr(prod_q, 5'd11);
        mul_b   = p6;
        state_d = ptc_pkg::ST_P_P5;
      end
      ptc_pkg::ST_P_P5: begin
        b_d     = prod_q;
        mul_en  = 1'b1;
        mul_a   = a_q;
        mul_b   = p5;
        state_d = ptc_pkg::ST_P_SUMB;
      end
      ptc_pkg::ST_P_SUMB: begin
        b_d     = b_q + {prod_q[30:0], 1'b0};
        mul_en  = 1'b1;
        mul_a   = p3;
        mul_b   = ptc_pkg::asr(qq_q, 5'd13);
        state_d = ptc_pkg::ST_P_P2;
      end
      ptc_pkg::ST_P_P2: begin
        b_d     = ptc_pkg::asr(b_q, 5'd2) + {p4[15:0], 16'd0};
        d_d     = ptc_pkg::asr(prod_q, 5'd3);
        mul_en  = 1'b1;
        mul_a   = p2;
        mul_b   = a_q;
        state_d = ptc_pkg::ST_P_SUMA;
      end
      ptc_pkg::ST_P_SUMA: begin
        a_d     = ptc_pkg::asr(d_q + ptc_pkg::asr(prod_q, 5'd1), 5'd18);
        d_d     = {11'd0, pn_q} - ptc_pkg::asr(b_q, 5'd12);
        state_d = ptc_pkg::ST_P_OFFS;
      end
      ptc_pkg::ST_P_OFFS: begin
        a_d     = a_q + ptc_pkg::ONE_Q15;
        state_d = ptc_pkg::ST_P_P1;
      end
      ptc_pkg::ST_P_P1: begin
        mul_en  = 1'b1;
        mul_a   = a_q;
        mul_b   = p1;
        state_d = ptc_pkg::ST_P_SCALE;
      end
      ptc_pkg::ST_P_SCALE: begin
        a_d     = ptc_pkg::asr(prod_q, 5'd15);
        mul_en  = 1'b1;
        mul_a   = d_q;
        mul_b   = ptc_pkg::PRESS_SCALE;
        state_d = ptc_pkg::ST_P_CHECK;
      end
      ptc_pkg::ST_P_CHECK: begin
        // A zero divisor forces the pressure to zero and raises the flag.
        if (a_q == '0) begin
          last_d  = '0;
          dz_d    = 1'b1;
          state_d = ptc_pkg::ST_OUT;
        end else begin
          dz_d          = 1'b0;
          branch_d      = !(prod_q < ptc_pkg::HALF_RANGE);
          div_req.start = 1'b1;
          state_d       = ptc_pkg::ST_DIV;
        end
      end
      ptc_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          p_d     = branch_q ? {div_rsp.quotient[30:0], 1'b0} : div_rsp.quotient;
          state_d = ptc_pkg::ST_C_SQ;
        end
      end
      ptc_pkg::ST_C_SQ: begin
        mul_en  = 1'b1;
        mul_a   = {3'd0, p_q[31:3]};
        mul_b   = {3'd0, p_q[31:3]};
        state_d = ptc_pkg::ST_C_P9;
      end
      ptc_pkg::ST_C_P9: begin
        mul_en  = 1'b1;
        mul_a   = p9;
        mul_b   = {13'd0, prod_q[31:13]};
        state_d = ptc_pkg::ST_C_P8;
      end
      ptc_pkg::ST_C_P8: begin
        a_d     = ptc_pkg::asr(prod_q, 5'd12);
        mul_en  = 1'b1;
        mul_a   = {2'd0, p_q[31:2]};
        mul_b   = p8;
        state_d = ptc_pkg::ST_C_SUM;
      end
      ptc_pkg::ST_C_SUM: begin
        a_d     = a_q + ptc_pkg::asr(prod_q, 5'd13) + p7;
        state_d = ptc_pkg::ST_C_FINAL;
      end
      ptc_pkg::ST_C_FINAL: begin
        last_d  = p_q + ptc_pkg::asr(a_q, 5'd4);
        state_d = ptc_pkg::ST_OUT;
      end
      ptc_pkg::ST_OUT: begin
        // Hand over to the output register once it is free.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_temp_d  = temp_q;
          out_fine_d  = fine_q;
          out_press_d = last_q;
          out_dz_d    = dz_q;
          state_d     = ptc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ptc_pkg::ST_IDLE;
      end
    endcase

    prod_d = mul_en ? mul_res : prod_q;
  end

  // Control state, calibration and the state kept between transactions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ptc_pkg::ST_IDLE;
      out_valid_q   <= 1'b0;
      fine_q        <= '0;
      last_q        <= '0;
      cal_temp_q    <= '0;
      cal_press_a_q <= '0;
      cal_press_b_q <= '0;
      cal_press_c_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      fine_q      <= fine_d;
      last_q      <= last_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ptc_pkg::CFG_CAL_TEMP:    cal_temp_q    <= cfg_wdata_i;
          ptc_pkg::CFG_CAL_PRESS_A: cal_press_a_q <= cfg_wdata_i;
          ptc_pkg::CFG_CAL_PRESS_B: cal_press_b_q <= cfg_wdata_i;
          ptc_pkg::CFG_CAL_PRESS_C: cal_press_c_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    a_q         <= a_d;
    b_q         <= b_d;
    d_q         <= d_d;
    qq_q        <= qq_d;
    p_q         <= p_d;
    prod_q      <= prod_d;
    temp_q      <= temp_d;
    pn_q        <= pn_d;
    dz_q        <= dz_d;
    branch_q    <= branch_d;
    out_temp_q  <= out_temp_d;
    out_fine_q  <= out_fine_d;
    out_press_q <= out_press_d;
    out_dz_q    <= out_dz_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.temp_centi    = $signed(out_temp_q);
  assign out_o.fine_temp_out = $signed(out_fine_q);
  assign out_o.pressure_pa   = out_press_q;
  assign out_o.div_zero      = out_dz_q;

  // Checks on the sequencer, the divider hand-off and the zero-divisor result.
  `PTC_ASSERT_NXT(a_busy_after_accept, in_acc, state_q != ptc_pkg::ST_IDLE, "block still idle after a transaction was accepted")
  `PTC_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider started while busy")
  `PTC_ASSERT_IMP(a_div_done_waited, div_rsp.done, state_q == ptc_pkg::ST_DIV, "divider finished with no one waiting")
  `PTC_ASSERT_IMP(a_div_zero_press, out_valid_q && out_dz_q, out_press_q == '0, "zero divisor flagged with a non-zero pressure")

endmodule

@@ test/tb_pressure_temperature_compensation.sv @@
// Self-checking testbench for the pressure and temperature compensation block.
// Depends on ptc_pkg, the channel interfaces in ptc_stream_if.sv and the block itself.
// A built-in integer compensation predictor checks every result against its own calculation.
`timescale 1ns / 1ps

module tb_pressure_temperature_compensation;

  // Cycles with no transaction, register write or result before the run is abandoned.
  localparam int unsigned QUIET_LIMIT  = 4000;
  // Settling time after the last result.
  localparam int unsigned SETTLE_TICKS = 64;
  localparam int unsigned RANDOM_ITEMS = 1030;
  localparam int unsigned REPORT_CAP   = 200;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
  } raw_sample_t;

  typedef struct packed {
    logic [31:0] temp_centi;
    logic [31:0] fine_temp;
    logic [31:0] pressure_pa;
    logic        div_zero;
  } reading_t;

  typedef struct packed {
    logic [47:0] temp;
    logic [47:0] press_a;
    logic [47:0] press_b;
    logic [47:0] press_c;
  } cal_set_t;

  typedef enum int {
    CAL_TYPICAL,
    CAL_ANY,
    CAL_NO_DIVISOR,
    CAL_FLAT_TEMP
  } cal_kind_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [47:0] cfg_wdata;

  ptc_in_if  in_if ();
  ptc_out_if out_if ();

  pressure_temperature_compensation u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Predictor copy of the calibration and of the block's state.
  logic [47:0] cal_regs [4];
  logic [31:0] fine_temp_q;
  logic [31:0] last_press_q;

  raw_sample_t raw_samples [$];
  reading_t    predicted_readings [$];

  int unsigned err_count;
  int unsigned quiet_cycles;
  int unsigned src_gap;
  int unsigned sink_stall;
  bit          sample_held;
  bit          src_eager;
  bit          sink_eager;

  // Clock generation.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Arithmetic right shift of a 32-bit two's complement word.
  function automatic logic [31:0] sra32(input logic [31:0] x, input int unsigned n);
    logic [63:0] ext;
    ext = {{32{x[31]}}, x} >> n;
    return ext[31:0];
  endfunction

  function automatic logic [31:0] sign16(input logic [15:0] x);
    logic signed [31:0] s;
    s = $signed(x);
    return s;
  endfunction

  // Integer compensation of one sample; updates the fine temperature and the held pressure.
  function automatic reading_t compensate_sample(input raw_sample_t s);
    logic [31:0] adc_t, adc_p;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] x, y, q, qq, dvs, prs;
    reading_t    r;
    adc_t = {12'd0, s.raw_temp};
    adc_p = {12'd0, s.raw_press};
    t1 = {16'd0, cal_regs[ptc_pkg::CFG_CAL_TEMP][15:0]};
    t2 = sign16(cal_regs[ptc_pkg::CFG_CAL_TEMP][31:16]);
    t3 = sign16(cal_regs[ptc_pkg::CFG_CAL_TEMP][47:32]);
    p1 = {16'd0, cal_regs[ptc_pkg::CFG_CAL_PRESS_A][15:0]};
    p2 = sign16(cal_regs[ptc_pkg::CFG_CAL_PRESS_A][31:16]);
    p3 = sign16(cal_regs[ptc_pkg::CFG_CAL_PRESS_A][47:32]);
    p4 = sign16(cal_regs[ptc_pkg::CFG_CAL_PRESS_B][15:0]);
    p5 = sign16(cal_regs[ptc_pkg::CFG_CAL_PRESS_B][31:16]);
    p6 = sign16(cal_regs[ptc_pkg::CFG_CAL_PRESS_B][47:32]);
    p7 = sign16(cal_regs[ptc_pkg::CFG_CAL_PRESS_C][15:0]);
    p8 = sign16(cal_regs[ptc_pkg::CFG_CAL_PRESS_C][31:16]);
    p9 = sign16(cal_regs[ptc_pkg::CFG_CAL_PRESS_C][47:32]);

    // Temperature: linear and quadratic terms give the fine temperature.
    x = (adc_t >> 3) - (t1 << 1);
    x = x * t2;
    y = (adc_t >> 4) - t1;
    y = y * y;
    y = sra32(y, 12) * t3;
    fine_temp_q = sra32(x, 11) + sra32(y, 14);
    x = fine_temp_q * ptc_pkg::TEMP_SCALE + ptc_pkg::ROUND_T;
    r.temp_centi = sra32(x, 8);
    r.fine_temp  = fine_temp_q;
    r.div_zero   = 1'b0;

    // Pressure is only recomputed for a non-zero fine temperature.
    if (fine_temp_q != '0) begin
      x  = sra32(fine_temp_q, 1) - ptc_pkg::PRESS_OFFSET;
      q  = sra32(x, 2);
      qq = q * q;
      y  = sra32(qq, 11) * p6;
      y  = y + ((x * p5) << 1);
      y  = sra32(y, 2) + (p4 << 16);
      x  = sra32(sra32(p3 * sra32(qq, 13), 3) + sra32(p2 * x, 1), 18);
      dvs = sra32((ptc_pkg::ONE_Q15 + x) * p1, 15);
      if (dvs == '0) begin
        prs = '0;
        r.div_zero = 1'b1;
      end else begin
        prs = ptc_pkg::RAW_FULL - adc_p;
        prs = (prs - sra32(y, 12)) * ptc_pkg::PRESS_SCALE;
        if (prs < ptc_pkg::HALF_RANGE) begin
          prs = (prs << 1) / dvs;
        end else begin
          prs = (prs / dvs) << 1;
        end
        q   = prs >> 3;
        qq  = (q * q) >> 13;
        x   = sra32(p9 * qq, 12);
        y   = sra32((prs >> 2) * p8, 13);
        prs = prs + sra32(x + y + p7, 4);
      end
      last_press_q = prs;
    end
    r.pressure_pa = last_press_q;
    return r;
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [15:0] jitter(input int centre, input int span);
    int v;
    v = centre + int'($urandom_range(0, 2 * span)) - span;
    return v[15:0];
  endfunction

  // Calibration sets: realistic values with some spread, or anything at all.
  function automatic cal_set_t make_cal(input cal_kind_e kind);
    cal_set_t c;
    if (kind == CAL_ANY) begin
      c.temp    = 48'({$urandom, $urandom});
      c.press_a = 48'({$urandom, $urandom});
      c.press_b = 48'({$urandom, $urandom});
      c.press_c = 48'({$urandom, $urandom});
    end else begin
      c.temp    = {jitter(-1000, 500), jitter(26435, 3000), jitter(27504, 3000)};
      c.press_a = {jitter(3024, 500), jitter(-10685, 2000), jitter(36477, 5000)};
      c.press_b = {jitter(-7, 20), jitter(140, 100), jitter(2855, 500)};
      c.press_c = {jitter(6000, 1000), jitter(-14600, 2000), jitter(15500, 2000)};
      if (kind == CAL_NO_DIVISOR) c.press_a[15:0] = 16'd0;
      if (kind == CAL_FLAT_TEMP) c.temp[47:16] = 32'd0;
    end
    return c;
  endfunction

  // Random sample: mostly in the sensor's usual range, some anywhere, and a few that
  // make the fine temperature cancel to zero under the current calibration.
  function automatic raw_sample_t make_sample();
    raw_sample_t s;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      s.raw_temp  = {cal_regs[ptc_pkg::CFG_CAL_TEMP][15:0], 1'b0, 3'($urandom)};
      s.raw_press = 20'($urandom);
    end else if (roll < 22) begin
      s.raw_temp  = 20'($urandom);
      s.raw_press = 20'($urandom);
    end else begin
      s.raw_temp  = 20'($urandom_range(380000, 620000));
      s.raw_press = 20'($urandom_range(150000, 600000));
    end
    return s;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    cal_regs[idx] = data;
  endtask

  task automatic load_calibration(input cal_set_t c);
    write_reg(ptc_pkg::CFG_CAL_TEMP, c.temp);
    write_reg(ptc_pkg::CFG_CAL_PRESS_A, c.press_a);
    write_reg(ptc_pkg::CFG_CAL_PRESS_B, c.press_b);
    write_reg(ptc_pkg::CFG_CAL_PRESS_C, c.press_c);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_sample(input int unsigned t, input int unsigned p);
    raw_sample_t s;
    s.raw_temp  = t[19:0];
    s.raw_press = p[19:0];
    raw_samples.push_back(s);
  endtask

  // Wait till all samples are sent and all predicted readings have arrived, then settle.
  task automatic drain_results();
    while (raw_samples.size() != 0 || sample_held || predicted_readings.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  // Sender and receiver: both change at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!sample_held) begin
        if (src_gap != 0) begin
          in_if.valid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (raw_samples.size() != 0) begin
          in_if.valid     <= 1'b1;
          in_if.raw_temp  <= raw_samples[0].raw_temp;
          in_if.raw_press <= raw_samples[0].raw_press;
          void'(raw_samples.pop_front());
          sample_held = 1'b1;
          src_gap <= src_eager ? 0 : pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      if (sink_stall != 0) begin
        out_if.ready <= 1'b0;
        sink_stall <= sink_stall - 1;
      end else begin
        out_if.ready <= 1'b1;
        if (!sink_eager && $urandom_range(0, 3) == 0) sink_stall <= pick_gap();
      end
    end
  end

  // Monitor: results are checked before the sample of the same edge is predicted.
  always @(posedge clk_i) begin
    reading_t want;
    raw_sample_t taken;
    bit moved;
    if (rst_ni) begin
      moved = cfg_we;
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        if (predicted_readings.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_CAP) begin
            $error("result with no reading pending: pressure_pa %0d", out_if.pressure_pa);
          end
        end else begin
          want = predicted_readings.pop_front();
          // Keep the log readable once things go badly wrong.
          if (out_if.temp_centi !== want.temp_centi) begin
            err_count++;
            if (err_count <= REPORT_CAP) begin
              $error("temp_centi: expected %0d, actual %0d",
                     $signed(want.temp_centi), out_if.temp_centi);
            end
          end
          if (out_if.fine_temp_out !== want.fine_temp) begin
            err_count++;
            if (err_count <= REPORT_CAP) begin
              $error("fine_temp_out: expected %0d, actual %0d",
                     $signed(want.fine_temp), out_if.fine_temp_out);
            end
          end
          if (out_if.pressure_pa !== want.pressure_pa) begin
            err_count++;
            if (err_count <= REPORT_CAP) begin
              $error("pressure_pa: expected %0d, actual %0d",
                     want.pressure_pa, out_if.pressure_pa);
            end
          end
          if (out_if.div_zero !== want.div_zero) begin
            err_count++;
            if (err_count <= REPORT_CAP) begin
              $error("div_zero: expected %0d, actual %0d", want.div_zero, out_if.div_zero);
            end
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        moved = 1'b1;
        taken.raw_temp  = in_if.raw_temp;
        taken.raw_press = in_if.raw_press;
        predicted_readings.push_back(compensate_sample(taken));
        sample_held = 1'b0;
      end
      // Watchdog on a stalled run.
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // Stimulus: directed phases first, then random phases with fresh calibration each.
  initial begin
    cal_set_t    c;
    int unsigned issued;
    int unsigned n;
    int unsigned roll;
    in_if.valid     = 1'b0;
    in_if.raw_temp  = '0;
    in_if.raw_press = '0;
    out_if.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = ptc_pkg::CFG_CAL_TEMP;
    cfg_wdata       = '0;
    for (int i = 0; i < 4; i++) cal_regs[i] = '0;
    fine_temp_q  = '0;
    last_press_q = '0;
    err_count    = 0;
    quiet_cycles = 0;
    src_gap      = 0;
    sink_stall   = 0;
    sample_held  = 1'b0;
    src_eager    = 1'b0;
    sink_eager   = 1'b0;
    rst_ni       = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Nominal calibration, field extremes and a cancelling fine temperature.
    c.temp    = {16'hFC18, 16'd26435, 16'd27504};
    c.press_a = {16'd3024, 16'hD643, 16'd36477};
    c.press_b = {16'hFFF9, 16'd140, 16'd2855};
    c.press_c = {16'd6000, 16'hC6F8, 16'd15500};
    load_calibration(c);
    queue_sample(519888, 415148);
    queue_sample(0, 0);
    queue_sample(20'hFFFFF, 20'hFFFFF);
    queue_sample(0, 20'hFFFFF);
    queue_sample(20'hFFFFF, 0);
    queue_sample(27504 * 16 + 5, 415148);
    queue_sample(400000, 300000);
    queue_sample(600000, 500000);
    drain_results();

    // No temperature slope: fine temperature is zero and the pressure is held.
    c.temp[47:16] = 32'd0;
    load_calibration(c);
    queue_sample(519888, 415148);
    queue_sample(20'hFFFFF, 0);
    drain_results();

    // Zero pressure divisor.
    c.temp    = {16'hFC18, 16'd26435, 16'd27504};
    c.press_a = {16'd3024, 16'hD643, 16'd0};
    load_calibration(c);
    queue_sample(519888, 415148);
    queue_sample(0, 20'hFFFFF);
    queue_sample(20'hFFFFF, 20'hFFFFF);
    drain_results();

    // Every calibration bit set.
    c = {4{48'hFFFF_FFFF_FFFF}};
    load_calibration(c);
    queue_sample(0, 0);
    queue_sample(20'hFFFFF, 20'hFFFFF);
    queue_sample(519888, 415148);
    drain_results();

    // Every calibration bit clear.
    c = '0;
    load_calibration(c);
    queue_sample(519888, 415148);
    queue_sample(0, 0);
    drain_results();

    // Signed words at their most positive and most negative.
    c.temp    = {16'h8000, 16'h7FFF, 16'hFFFF};
    c.press_a = {16'h7FFF, 16'h8000, 16'hFFFF};
    c.press_b = {16'h8000, 16'h7FFF, 16'h7FFF};
    c.press_c = {16'h7FFF, 16'h8000, 16'h8000};
    load_calibration(c);
    queue_sample(20'hFFFFF, 20'hFFFFF);
    queue_sample(20'h80000, 20'h7FFFF);
    queue_sample(0, 20'hFFFFF);
    drain_results();

    // Random phases.
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) c = make_cal(CAL_TYPICAL);
      else if (roll < 80) c = make_cal(CAL_ANY);
      else if (roll < 90) c = make_cal(CAL_NO_DIVISOR);
      else c = make_cal(CAL_FLAT_TEMP);
      load_calibration(c);
      src_eager  = ($urandom_range(0, 4) == 0);
      sink_eager = ($urandom_range(0, 4) == 0);
      n = $urandom_range(70, 100);
      for (int k = 0; k < n; k++) raw_samples.push_back(make_sample());
      issued += n;
      drain_results();
    end

    if (err_count == 0 && predicted_readings.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ pressure_temperature_compensation.f @@
+incdir+rtl
rtl/ptc_pkg.sv
rtl/ptc_stream_if.sv
rtl/ptc_div.sv
rtl/pressure_temperature_compensation.sv
test/tb_pressure_temperature_compensation.sv
